### src/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg
// shared codes and types for the sorted breakpoint table
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int LINE_BITS_DEF   = 16;

  // request actions
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic     cmp;
    cell_op_t op;
  } cell_cmd_t;

endpackage

### src/sbt_cell.sv
// ----------------------------------------------------------------------------
// sbt_cell
// one table slot: compares against the broadcast line and shifts with neighbors
// ----------------------------------------------------------------------------
module sbt_cell #(
  parameter int LINE_BITS = sbt_pkg::LINE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sbt_pkg::cell_cmd_t    cmd,
  input  logic [LINE_BITS-1:0]  line,
  input  logic [LINE_BITS-1:0]  left_slot,
  input  logic                  left_lt,
  input  logic [LINE_BITS-1:0]  right_slot,
  output logic [LINE_BITS-1:0]  slot,
  output logic                  lt,
  output logic                  eq
);
  import sbt_pkg::*;

  logic occupied;

  assign occupied = (slot != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      lt   <= 1'b0;
      eq   <= 1'b0;
    end else begin
      if (cmd.cmp) begin
        lt <= occupied && (slot < line);
        eq <= occupied && (slot == line);
      end
      case (cmd.op)
        CELL_INSERT: begin
          // smaller entries stay, the first slot that is not smaller takes the line
          if (!lt) begin
            slot <= left_lt ? line : left_slot;
          end
        end
        CELL_REMOVE: begin
          if (!lt) begin
            slot <= right_slot;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### src/sorted_breakpoint_table.sv
// ----------------------------------------------------------------------------
// sorted_breakpoint_table
// ascending, duplicate-free table of breakpoint lines held in a row of cells
// ----------------------------------------------------------------------------
// each request makes a compare pass through the cell row, which is registered;
//   then the row shifts and the result is written; a new request is taken only
//   in idle or while the previous one is applied, and a blocked result holds apply
// reset: rst (synchronous) empties every slot, clears count, active flag and
//   trace_on; the block takes requests in the first cycle after reset
module sorted_breakpoint_table #(
  parameter int TABLE_DEPTH = sbt_pkg::TABLE_DEPTH_DEF,
  parameter int LINE_BITS   = sbt_pkg::LINE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic                 cfg_data,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           action,
  input  logic [LINE_BITS-1:0] line,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           status,
  output logic [3:0]           position,
  output logic [4:0]           entry_count,
  output logic                 break_active
);
  import sbt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  state_t               state;
  logic                 trace_on;
  logic [1:0]           req_action;
  logic [LINE_BITS-1:0] req_line;
  logic [CNT_W-1:0]     count;
  logic                 active;

  // cell row wiring
  logic [LINE_BITS-1:0] slot_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_q;
  logic [TABLE_DEPTH-1:0] eq_q;
  cell_cmd_t            cell_cmd;

  // apply decisions
  logic                 out_free;
  logic                 apply_go;
  logic                 accept;
  logic                 found;
  logic                 full;
  logic [IDX_W-1:0]     ins_idx;
  logic [IDX_W-1:0]     hit_idx;
  logic [2:0]           status_next;
  logic [IDX_W-1:0]     pos_next;
  logic [CNT_W-1:0]     count_next;
  logic                 active_next;
  cell_op_t             op_next;

  // output register frees when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign apply_go = (state == S_APPLY) && out_free;
  // a new request can enter in the same cycle the previous one is applied
  assign in_stall = !((state == S_IDLE) || apply_go);
  assign accept   = in_valid && !in_stall;

  assign cell_cmd.cmp = (state == S_CMP);
  assign cell_cmd.op  = apply_go ? op_next : CELL_HOLD;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic [LINE_BITS-1:0] left_slot;
      logic                 left_lt;
      logic [LINE_BITS-1:0] right_slot;

      if (g == 0) begin : g_first
        // the head slot always sees a smaller left neighbor
        assign left_slot = '0;
        assign left_lt   = 1'b1;
      end else begin : g_mid
        assign left_slot = slot_q[g-1];
        assign left_lt   = lt_q[g-1];
      end

      if (g == TABLE_DEPTH - 1) begin : g_last
        assign right_slot = '0;
      end else begin : g_inner
        assign right_slot = slot_q[g+1];
      end

      sbt_cell #(
        .LINE_BITS (LINE_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cell_cmd),
        .line       (req_line),
        .left_slot  (left_slot),
        .left_lt    (left_lt),
        .right_slot (right_slot),
        .slot       (slot_q[g]),
        .lt         (lt_q[g]),
        .eq         (eq_q[g])
      );
    end
  endgenerate

  // the smaller-than bits form a thermometer, so the insert slot is the one
  // edge in it; a hit is one-hot; both encode through an or of indexes
  always_comb begin
    ins_idx = '0;
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!lt_q[i] && ((i == 0) || lt_q[(i == 0) ? 0 : i - 1])) begin
        ins_idx = ins_idx | IDX_W'(i);
      end
      if (eq_q[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign found = |eq_q;
  assign full  = (count == CNT_W'(TABLE_DEPTH));

  always_comb begin
    status_next = ST_OK;
    pos_next    = '0;
    count_next  = count;
    active_next = active;
    op_next     = CELL_HOLD;
    case (req_action)
      ACT_INSERT: begin
        if (req_line == '0) begin
          status_next = ST_ZERO;
        end else if (found) begin
          status_next = ST_DUP;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          pos_next    = ins_idx;
          count_next  = count + CNT_W'(1);
          active_next = 1'b1;
          op_next     = CELL_INSERT;
        end
      end
      ACT_REMOVE: begin
        if (req_line == '0) begin
          status_next = ST_ZERO;
        end else if (!found) begin
          status_next = ST_NOTFOUND;
        end else begin
          pos_next   = hit_idx;
          count_next = count - CNT_W'(1);
          op_next    = CELL_REMOVE;
        end
        // an empty table drops the flag after any remove unless tracing holds it
        if ((count_next == '0) && !trace_on) begin
          active_next = 1'b0;
        end
      end
      ACT_FIND: begin
        if (found && (req_line != '0)) begin
          pos_next = hit_idx;
        end else begin
          status_next = ST_NOTFOUND;
        end
      end
      default: begin
        status_next = ST_NOTFOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_line   <= line;
    end
    if (rst) begin
      state     <= S_IDLE;
      trace_on  <= 1'b0;
      count     <= '0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        trace_on <= cfg_data;
      end
      // a new result replaces one being taken; otherwise a taken result clears
      if (apply_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (apply_go) begin
            count        <= count_next;
            active       <= active_next;
            status       <= status_next;
            position     <= 4'(pos_next);
            entry_count  <= 5'(count_next);
            break_active <= active_next;
            state        <= accept ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // count never runs past the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("count beyond table depth");

  // head slot occupancy agrees with the count
  a_head_occupancy: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == (slot_q[0] == '0))
    else $error("head slot disagrees with count");

  // failed requests report slot zero
  a_error_position: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (position == 4'd0))
    else $error("nonzero position on error");

  // a blocked result keeps the pending request parked in apply
  a_apply_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == S_APPLY) && out_valid && out_stall) |=> (state == S_APPLY))
    else $error("apply left while output blocked");
`endif

endmodule

### test/sorted_breakpoint_table_tb.sv
// ----------------------------------------------------------------------------
// sorted_breakpoint_table testbench
// drives insert, remove and find requests into the breakpoint table, tracks
// the sorted table, count and active flag in a shadow copy and compares every
// result field by field; random bursts and gaps on the request side, a
// changing stall pattern with long hold-offs on the result side, and trace_on
// toggled between phases while the block is idle
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbt_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int LINE_BITS   = LINE_BITS_DEF;
  localparam int POOL_N      = 22;       // a few more lines than slots, so the table fills
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_CAP  = 50;

  // action code with no meaning in the block; it must answer not found
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]           op;
    logic [LINE_BITS-1:0] ln;
  } bp_request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] position;
    logic [4:0] entry_count;
    logic       brk_active;
  } bp_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // block inputs, all known from time zero
  logic                 cfg_write = 1'b0;
  logic                 cfg_data  = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [1:0]           action    = ACT_FIND;
  logic [LINE_BITS-1:0] line      = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b1;
  logic [2:0]           status;
  logic [3:0]           position;
  logic [4:0]           entry_count;
  logic                 break_active;

  sorted_breakpoint_table dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .line         (line),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .position     (position),
    .entry_count  (entry_count),
    .break_active (break_active)
  );

  // shadow of the table: sorted lines, count, active flag and trace setting
  logic [LINE_BITS-1:0] bp_slots [TABLE_DEPTH] = '{default: '0};
  int                   held         = 0;
  logic                 armed        = 1'b0;
  logic                 trace_shadow = 1'b0;

  bp_request_t          pending_requests [$];
  bp_result_t           expected_results [$];
  logic [LINE_BITS-1:0] line_pool [POOL_N];

  int n_sent     = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int errors     = 0;
  int cycle_count = 0;

  // applies one request to the shadow table and returns the result it must give
  function automatic bp_result_t table_step(input logic [1:0] op,
                                            input logic [LINE_BITS-1:0] ln);
    bp_result_t r;
    int hit;
    int slot_at;
    int i;
    r = '0;
    r.status = ST_OK;
    // occupied slots never hold zero, so a zero line never hits
    hit = -1;
    for (i = 0; i < held; i++)
      if (bp_slots[i] == ln) hit = i;
    case (op)
      ACT_INSERT: begin
        if (ln == '0) r.status = ST_ZERO;
        else if (hit >= 0) r.status = ST_DUP;
        else if (held >= TABLE_DEPTH) r.status = ST_FULL;
        else begin
          // first slot whose entry is larger; everything from there moves up
          slot_at = 0;
          while (slot_at < held && bp_slots[slot_at] < ln) slot_at++;
          for (i = held; i > slot_at; i--) bp_slots[i] = bp_slots[i-1];
          bp_slots[slot_at] = ln;
          held++;
          armed = 1'b1;
          r.position = 4'(slot_at);
        end
      end
      ACT_REMOVE: begin
        if (ln == '0) r.status = ST_ZERO;
        else if (hit < 0) r.status = ST_NOTFOUND;
        else begin
          for (i = hit; i < held - 1; i++) bp_slots[i] = bp_slots[i+1];
          bp_slots[held-1] = '0;
          held--;
          r.position = 4'(hit);
        end
        // an empty table drops the flag after any remove, failed ones too,
        // unless tracing keeps it up
        if (held == 0 && !trace_shadow) armed = 1'b0;
      end
      ACT_FIND: begin
        if (hit < 0) r.status = ST_NOTFOUND;
        else r.position = 4'(hit);
      end
      default: begin
        r.status = ST_NOTFOUND;
      end
    endcase
    r.entry_count = 5'(held);
    r.brk_active  = armed;
    return r;
  endfunction

  task automatic push_request(input logic [1:0] op, input logic [LINE_BITS-1:0] ln);
    bp_request_t req;
    req.op = op;
    req.ln = ln;
    pending_requests.push_back(req);
    n_sent++;
  endtask

  // new set of candidate lines, with the extremes showing up now and then
  task automatic refresh_pool();
    int k;
    int pick;
    for (k = 0; k < POOL_N; k++) begin
      pick = $urandom_range(19);
      if (pick == 0) line_pool[k] = 16'd1;
      else if (pick == 1) line_pool[k] = 16'hffff;
      else line_pool[k] = LINE_BITS'($urandom_range(65535, 1));
    end
  endtask

  // random requests mostly on pool lines, so hits, duplicates and a full table
  // come up often; insert_pct sets whether the table drifts up or down
  task automatic push_random_phase(input int n, input int insert_pct);
    int k;
    int roll;
    logic [LINE_BITS-1:0] pick;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      pick = line_pool[$urandom_range(POOL_N - 1)];
      if (roll < 2) push_request(ACT_UNUSED, LINE_BITS'($urandom));
      else if (roll < 4) push_request(LINE_BITS'(0) == 0 ? 2'($urandom_range(2)) : ACT_FIND,
                                      '0);
      else if (roll < 8) push_request($urandom_range(1) ? ACT_FIND : ACT_REMOVE,
                                      LINE_BITS'($urandom));
      else if ($urandom_range(99) < insert_pct) push_request(ACT_INSERT, pick);
      else if ($urandom_range(99) < 55) push_request(ACT_REMOVE, pick);
      else push_request(ACT_FIND, pick);
    end
  endtask

  // removes every pool line; inserts only ever come from the pool, so the
  // table ends up empty
  task automatic push_pool_clear();
    int k;
    for (k = 0; k < POOL_N; k++) push_request(ACT_REMOVE, line_pool[k]);
  endtask

  // sender holds back until every request has been taken and answered
  task automatic wait_idle();
    while (n_accepted != n_sent || pending_requests.size() != 0 ||
           expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_trace(input logic value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    trace_shadow = value;
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name,
                 want_v, got_v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length separated by random gaps; a
  // stalled request keeps its payload and valid until it is taken
  // ---------------------------------------------------------------------------
  int          burst_left = 1;
  int          gap_left   = 0;
  bp_request_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // request taken at this edge: predict its result now
      if (in_valid && !in_stall) begin
        expected_results.push_back(table_step(action, line));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_requests.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          nxt = pending_requests.pop_front();
          in_valid <= 1'b1;
          action   <= nxt.op;
          line     <= nxt.ln;
          // a quarter of the bursts run straight into the next one
          if (burst_left <= 1) begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and stall pattern: modes of no stall, light, heavy and
  // periodic stalls, each for a random stretch; every 400 results a long
  // hold-off lets the block fill up and stall its request side
  // ---------------------------------------------------------------------------
  bp_result_t want;
  int         hold_left  = 0;
  int         mode_left  = 0;
  int         stall_mode = 0;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, actual status %0d line slot %0d",
                   $realtime, status, position);
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, status);
        check_field("position", want.position, position);
        check_field("entry_count", want.entry_count, entry_count);
        check_field("break_active", want.brk_active, break_active);
      end
      n_checked++;
      if (n_checked % 400 == 200) hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(3);
        mode_left  = $urandom_range(60, 10);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(9) < 3);
        2: out_stall <= ($urandom_range(9) < 7);
        default: out_stall <= (mode_left % 3 == 0);
      endcase
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sorted_breakpoint_table verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed corner requests, then random phases under both trace
  // settings, with the block idle around every trace_on write
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_trace(1'b0);

    @(negedge clk);
    // empty table: misses, zero lines, unknown action
    push_request(ACT_FIND, 16'd5);
    push_request(ACT_REMOVE, 16'd5);
    push_request(ACT_INSERT, 16'd0);
    push_request(ACT_REMOVE, 16'd0);
    push_request(ACT_FIND, 16'd0);
    push_request(ACT_UNUSED, 16'd7);
    // inserts in and out of order, duplicate, finds at both ends
    push_request(ACT_INSERT, 16'h8000);
    push_request(ACT_INSERT, 16'hffff);
    push_request(ACT_INSERT, 16'd1);
    push_request(ACT_INSERT, 16'h8000);
    push_request(ACT_FIND, 16'd1);
    push_request(ACT_FIND, 16'hffff);
    push_request(ACT_FIND, 16'h7fff);
    push_request(ACT_UNUSED, 16'hffff);
    // removes from the middle, the front and the last entry
    push_request(ACT_REMOVE, 16'h8000);
    push_request(ACT_REMOVE, 16'd1);
    push_request(ACT_REMOVE, 16'hffff);
    push_request(ACT_REMOVE, 16'hffff);
    push_request(ACT_INSERT, 16'h5555);
    push_request(ACT_INSERT, 16'haaaa);
    push_request(ACT_FIND, 16'haaaa);
    push_request(ACT_REMOVE, 16'h5555);
    push_request(ACT_REMOVE, 16'haaaa);
    wait_idle();

    // tracing on: fill to full, then empty while the flag stays up
    write_trace(1'b1);
    @(negedge clk);
    refresh_pool();
    push_random_phase(300, 65);
    push_pool_clear();
    push_request(ACT_REMOVE, 16'h1234);
    wait_idle();

    // tracing off: a failed remove on the empty table drops the flag
    write_trace(1'b0);
    @(negedge clk);
    push_request(ACT_REMOVE, 16'h1234);
    refresh_pool();
    push_random_phase(300, 45);
    push_pool_clear();
    wait_idle();

    write_trace(1'b1);
    @(negedge clk);
    refresh_pool();
    push_random_phase(250, 55);
    wait_idle();

    write_trace(1'b0);
    @(negedge clk);
    push_random_phase(200, 35);
    wait_idle();

    // let any stray result show up before the verdict
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("sorted_breakpoint_table verification clean");
    end else begin
      $display("sorted_breakpoint_table verification failed");
    end
    $finish;
  end

endmodule
